// ===== sv/aetd_pkg.sv =====
`default_nettype none
package aetd_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int DUTY_BITS   = 10;
	localparam int SHIFT_BITS  = 4;
	localparam int INDEX_BITS  = 3;

	localparam logic [SAMPLE_BITS-1:0] MIDPOINT_RESET = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
	localparam logic [SAMPLE_BITS-1:0] FLOOR_RESET    = SAMPLE_BITS'(18);
	localparam logic [SAMPLE_BITS-1:0] FULL_RESET     = SAMPLE_BITS'(850);
	localparam logic [SHIFT_BITS-1:0]  MID_SHIFT_RESET = SHIFT_BITS'(8);
	localparam logic [SHIFT_BITS-1:0]  ATK_SHIFT_RESET = SHIFT_BITS'(2);
	localparam logic [SHIFT_BITS-1:0]  REL_SHIFT_RESET = SHIFT_BITS'(5);

	typedef enum logic [INDEX_BITS-1:0] {
		REG_NOISE_FLOOR    = 3'd0,
		REG_FULL_SCALE     = 3'd1,
		REG_MID_SHIFT      = 3'd2,
		REG_ATTACK_SHIFT   = 3'd3,
		REG_RELEASE_SHIFT  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] noise_floor;
		logic [SAMPLE_BITS-1:0] full_scale;
		logic [SHIFT_BITS-1:0]  mid_shift;
		logic [SHIFT_BITS-1:0]  attack_shift;
		logic [SHIFT_BITS-1:0]  release_shift;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MSHIFT,
		ST_MADD,
		ST_AMP,
		ST_ECMP,
		ST_ESHIFT,
		ST_EADD,
		ST_DUTY,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== sv/aetd_in_if.sv =====
`default_nettype none
interface aetd_in_if
	import aetd_pkg::*;
	;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== sv/aetd_out_if.sv =====
`default_nettype none
interface aetd_out_if
	import aetd_pkg::*;
	;
	logic                   valid;
	logic                   ready;
	logic [DUTY_BITS-1:0]   pwm_duty;
	logic [SAMPLE_BITS-1:0] envelope;
	logic [SAMPLE_BITS-1:0] amplitude;
	logic [SAMPLE_BITS-1:0] midpoint;

	modport source (output valid, output pwm_duty, output envelope, output amplitude,
		output midpoint, input ready);
	modport sink (input valid, input pwm_duty, input envelope, input amplitude,
		input midpoint, output ready);
endinterface
`default_nettype wire

// ===== sv/aetd_cfg.sv =====
`default_nettype none
module aetd_cfg
	import aetd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [INDEX_BITS-1:0]  cfg_index,
	input  wire logic [SAMPLE_BITS-1:0] cfg_wdata,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_floor    <= FLOOR_RESET;
			cfg_q.full_scale     <= FULL_RESET;
			cfg_q.mid_shift      <= MID_SHIFT_RESET;
			cfg_q.attack_shift   <= ATK_SHIFT_RESET;
			cfg_q.release_shift  <= REL_SHIFT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NOISE_FLOOR:    cfg_q.noise_floor    <= cfg_wdata;
				REG_FULL_SCALE:     cfg_q.full_scale     <= cfg_wdata;
				REG_MID_SHIFT:      cfg_q.mid_shift      <= cfg_wdata[SHIFT_BITS-1:0];
				REG_ATTACK_SHIFT:   cfg_q.attack_shift   <= cfg_wdata[SHIFT_BITS-1:0];
				REG_RELEASE_SHIFT:  cfg_q.release_shift  <= cfg_wdata[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== sv/audio_envelope_to_duty_top.sv =====
// Envelope follower that turns 12-bit audio samples into a 10-bit PWM duty. Each accepted
// sample produces exactly one result transaction carrying the duty, the updated envelope,
// the amplitude and the updated midpoint. The block works on one sample at a time: all
// shifts run one bit per cycle and the duty is found by a one-bit-per-cycle restoring
// divider, so a new sample is accepted only once the last one has been through the
// midpoint shift, the envelope shift by S, where S is attack_shift on a rising envelope
// and release_shift otherwise, and, whenever the envelope lies above the noise floor,
// the division. A finished result sits in an output register, so the next sample is
// taken while it waits. Configuration writes are meant for an idle block only.
`default_nettype none
module audio_envelope_to_duty_top
	import aetd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [INDEX_BITS-1:0]  cfg_index,
	input  wire logic [SAMPLE_BITS-1:0] cfg_wdata,
	aetd_in_if.sink                     samples,
	aetd_out_if.source                  results
);

	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int PROD_BITS = SAMPLE_BITS + DUTY_BITS;
	localparam int CNT_BITS  = 4;
	localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DUTY_BITS - 1);

	cfg_t cfg;

	aetd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0]      sample_q;
	logic [SAMPLE_BITS-1:0]      mid_q;
	logic [SAMPLE_BITS-1:0]      env_q;
	logic [SAMPLE_BITS-1:0]      amp_q;
	logic [SAMPLE_BITS-1:0]      span_q;
	logic [SAMPLE_BITS-1:0]      rem_q;
	logic [DUTY_BITS-1:0]        quo_q;
	logic signed [DIFF_BITS-1:0] sh_q;
	logic [CNT_BITS-1:0]         cnt_q;
	logic                        up_q;
	logic                        out_valid_q;
	logic [DUTY_BITS-1:0]        out_duty_q;
	logic [SAMPLE_BITS-1:0]      out_env_q;
	logic [SAMPLE_BITS-1:0]      out_amp_q;
	logic [SAMPLE_BITS-1:0]      out_mid_q;

	logic                        in_fire;
	logic                        load_out;
	logic                        above_floor;
	logic [DIFF_BITS-1:0]        mid_sum;
	logic [SAMPLE_BITS-1:0]      active;
	logic [SAMPLE_BITS-1:0]      active_sat;
	logic [PROD_BITS-1:0]        prod;
	logic [DIFF_BITS-1:0]        trial;
	logic                        trial_ge;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_fire       = samples.valid && samples.ready;
	assign load_out      = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	assign above_floor = env_q > cfg.noise_floor;
	assign mid_sum     = {1'b0, mid_q} + DIFF_BITS'(sh_q);
	assign active      = env_q - cfg.noise_floor;
	assign active_sat  = (active > span_q) ? span_q : active;
	assign prod        = {active_sat, DUTY_BITS'(0)} - PROD_BITS'(active_sat);
	assign trial       = {rem_q, quo_q[DUTY_BITS-1]};
	assign trial_ge    = trial >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_MSHIFT;
			ST_MSHIFT: if (cnt_q == '0) state_d = ST_MADD;
			ST_MADD:   state_d = ST_AMP;
			ST_AMP:    state_d = ST_ECMP;
			ST_ECMP:   state_d = ST_ESHIFT;
			ST_ESHIFT: if (cnt_q == '0) state_d = ST_EADD;
			ST_EADD:   state_d = ST_DUTY;
			ST_DUTY:   state_d = above_floor ? ST_DIV : ST_DONE;
			ST_DIV:    if (cnt_q == '0) state_d = ST_DONE;
			ST_DONE:   if (load_out) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= MIDPOINT_RESET;
			env_q <= '0;
		end else begin
			case (state_q)
				ST_MADD: mid_q <= mid_sum[SAMPLE_BITS-1:0];
				ST_EADD: env_q <= up_q ? env_q + sh_q[SAMPLE_BITS-1:0]
					: env_q - sh_q[SAMPLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The shift register holds a signed difference, so shifting it right one bit per
	// cycle floors toward minus infinity.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sample_q <= samples.sample;
				sh_q     <= $signed({1'b0, samples.sample}) - $signed({1'b0, mid_q});
				cnt_q    <= cfg.mid_shift;
			end
			ST_MSHIFT, ST_ESHIFT: begin
				if (cnt_q != '0) begin
					sh_q  <= sh_q >>> 1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_AMP: begin
				amp_q <= (sample_q >= mid_q) ? sample_q - mid_q : mid_q - sample_q;
			end
			ST_ECMP: begin
				up_q   <= amp_q > env_q;
				sh_q   <= (amp_q > env_q) ? {1'b0, amp_q - env_q} : {1'b0, env_q - amp_q};
				cnt_q  <= (amp_q > env_q) ? cfg.attack_shift : cfg.release_shift;
				span_q <= (cfg.full_scale > cfg.noise_floor)
					? cfg.full_scale - cfg.noise_floor : SAMPLE_BITS'(1);
			end
			ST_DUTY: begin
				rem_q <= above_floor ? prod[PROD_BITS-1:DUTY_BITS] : '0;
				quo_q <= above_floor ? prod[DUTY_BITS-1:0] : '0;
				cnt_q <= DIV_LAST;
			end
			ST_DIV: begin
				rem_q <= trial_ge ? SAMPLE_BITS'(trial - {1'b0, span_q})
					: trial[SAMPLE_BITS-1:0];
				quo_q <= {quo_q[DUTY_BITS-2:0], trial_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_duty_q <= quo_q;
			out_env_q  <= env_q;
			out_amp_q  <= amp_q;
			out_mid_q  <= mid_q;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.pwm_duty  = out_duty_q;
	assign results.envelope  = out_env_q;
	assign results.amplitude = out_amp_q;
	assign results.midpoint  = out_mid_q;

endmodule
`default_nettype wire

// ===== dv/audio_envelope_to_duty_top_tb.sv =====
`default_nettype none
module audio_envelope_to_duty_top_tb;
	import aetd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DUTY_FULL    = (1 << DUTY_BITS) - 1;
	localparam int SAMPLE_FULL  = (1 << SAMPLE_BITS) - 1;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int IDLE_GUARD   = 8;
	localparam int TAIL_CYCLES  = 60;
	localparam int LONG_HOLD    = 400;
	localparam int STALL_LIMIT  = 3000;

	typedef struct packed {
		logic [DUTY_BITS-1:0]   duty;
		logic [SAMPLE_BITS-1:0] env;
		logic [SAMPLE_BITS-1:0] amp;
		logic [SAMPLE_BITS-1:0] mid;
	} follow_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_SAMPLE,
		ROW_CHECKED
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		cfg_reg_t               idx;
		logic [SAMPLE_BITS-1:0] value;
		follow_t                lit;
	} row_t;

	typedef enum int {
		WAVE_TONE,
		WAVE_NOISE,
		WAVE_QUIET,
		WAVE_RAIL
	} wave_t;

	typedef enum int {
		PACE_FREE,
		PACE_COIN,
		PACE_SPARSE,
		PACE_PATTERN
	} pace_t;

	localparam follow_t NO_LIT = '0;

	localparam row_t DIRECTED [0:38] = '{
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd2048, '{10'd0, 12'd0, 12'd0, 12'd2048}},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd4095, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd0, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd2048, NO_LIT},
		'{ROW_WRITE, REG_MID_SHIFT, 12'd0, NO_LIT},
		'{ROW_WRITE, REG_ATTACK_SHIFT, 12'd0, NO_LIT},
		'{ROW_WRITE, REG_RELEASE_SHIFT, 12'd0, NO_LIT},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd4095, '{10'd0, 12'd0, 12'd0, 12'd4095}},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd0, '{10'd0, 12'd0, 12'd0, 12'd0}},
		'{ROW_WRITE, REG_MID_SHIFT, 12'd15, NO_LIT},
		'{ROW_WRITE, REG_RELEASE_SHIFT, 12'd15, NO_LIT},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd4095, '{10'd1023, 12'd4095, 12'd4095, 12'd0}},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd0, '{10'd1023, 12'd4095, 12'd0, 12'd0}},
		'{ROW_WRITE, REG_NOISE_FLOOR, 12'd100, NO_LIT},
		'{ROW_WRITE, REG_FULL_SCALE, 12'd50, NO_LIT},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd2048, '{10'd1023, 12'd4095, 12'd2048, 12'd0}},
		'{ROW_WRITE, REG_RELEASE_SHIFT, 12'd0, NO_LIT},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd101, '{10'd1023, 12'd101, 12'd101, 12'd0}},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd100, '{10'd0, 12'd100, 12'd100, 12'd0}},
		'{ROW_WRITE, REG_NOISE_FLOOR, 12'd4095, NO_LIT},
		'{ROW_WRITE, REG_FULL_SCALE, 12'd4095, NO_LIT},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd4095, '{10'd0, 12'd4095, 12'd4095, 12'd0}},
		'{ROW_WRITE, REG_NOISE_FLOOR, 12'd0, NO_LIT},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd4095, '{10'd1023, 12'd4095, 12'd4095, 12'd0}},
		'{ROW_CHECKED, REG_NOISE_FLOOR, 12'd1, '{10'd0, 12'd1, 12'd1, 12'd0}},
		'{ROW_WRITE, REG_NOISE_FLOOR, 12'd18, NO_LIT},
		'{ROW_WRITE, REG_FULL_SCALE, 12'd850, NO_LIT},
		'{ROW_WRITE, REG_MID_SHIFT, 12'd1, NO_LIT},
		'{ROW_WRITE, REG_ATTACK_SHIFT, 12'd15, NO_LIT},
		'{ROW_WRITE, REG_RELEASE_SHIFT, 12'd7, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd4095, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd0, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd1022, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd2730, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd1365, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd19, NO_LIT},
		'{ROW_WRITE, REG_FULL_SCALE, 12'd19, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd2048, NO_LIT},
		'{ROW_SAMPLE, REG_NOISE_FLOOR, 12'd4095, NO_LIT}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	cfg_reg_t               cfg_index;
	logic [SAMPLE_BITS-1:0] cfg_wdata;

	aetd_in_if  sample_ch ();
	aetd_out_if result_ch ();

	audio_envelope_to_duty_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.samples   (sample_ch),
		.results   (result_ch)
	);

	int floor_lvl;
	int full_lvl;
	int mid_sh;
	int atk_sh;
	int rel_sh;
	int mid_est;
	int env_est;

	follow_t pending [$];
	int      mismatches;
	int      burst_left;
	int      idle_cycles;
	bit      long_hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic follow_t advance_follower(input logic [SAMPLE_BITS-1:0] s);
		int      d;
		int      a;
		int      span;
		int      act;
		follow_t r;
		d = int'(s) - mid_est;
		mid_est = (mid_est + (d >>> mid_sh)) & SAMPLE_FULL;
		a = (int'(s) >= mid_est) ? int'(s) - mid_est : mid_est - int'(s);
		if (a > env_est)
			env_est = env_est + ((a - env_est) >>> atk_sh);
		else
			env_est = env_est - ((env_est - a) >>> rel_sh);
		env_est &= SAMPLE_FULL;
		if (env_est <= floor_lvl) begin
			r.duty = '0;
		end else begin
			span = (full_lvl > floor_lvl) ? full_lvl - floor_lvl : 1;
			act = env_est - floor_lvl;
			if (act > span)
				act = span;
			r.duty = DUTY_BITS'((act * DUTY_FULL) / span);
		end
		r.env = SAMPLE_BITS'(env_est);
		r.amp = SAMPLE_BITS'(a);
		r.mid = SAMPLE_BITS'(mid_est);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input bit use_lit,
		input follow_t lit);
		int      gap;
		follow_t want;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		do @(posedge clk); while (!sample_ch.ready);
		want = advance_follower(s);
		pending.push_back(use_lit ? lit : want);
		burst_left--;
		@(negedge clk);
	endtask

	// Stops offering samples and waits until the block has delivered everything.
	task automatic settle_block();
		sample_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending.size() != 0)
			@(negedge clk);
		repeat (IDLE_GUARD) @(negedge clk);
	endtask

	task automatic write_cfg(input cfg_reg_t idx, input int value);
		case (idx)
			REG_NOISE_FLOOR:    floor_lvl = value & SAMPLE_FULL;
			REG_FULL_SCALE:     full_lvl = value & SAMPLE_FULL;
			REG_MID_SHIFT:      mid_sh = value & 15;
			REG_ATTACK_SHIFT:   atk_sh = value & 15;
			REG_RELEASE_SHIFT:  rel_sh = value & 15;
			default: ;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= SAMPLE_BITS'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic pick_config(input int phase_no);
		int fl;
		int fs;
		settle_block();
		if (phase_no == 1) begin
			write_cfg(REG_NOISE_FLOOR, 0);
			write_cfg(REG_FULL_SCALE, SAMPLE_FULL);
			write_cfg(REG_MID_SHIFT, 15);
			write_cfg(REG_ATTACK_SHIFT, 15);
			write_cfg(REG_RELEASE_SHIFT, 15);
		end else if (phase_no == 2) begin
			write_cfg(REG_NOISE_FLOOR, SAMPLE_FULL);
			write_cfg(REG_FULL_SCALE, 0);
			write_cfg(REG_MID_SHIFT, 0);
			write_cfg(REG_ATTACK_SHIFT, 0);
			write_cfg(REG_RELEASE_SHIFT, 0);
		end else begin
			fl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SAMPLE_FULL)
				: $urandom_range(0, 200);
			fs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SAMPLE_FULL)
				: fl + $urandom_range(1, 1500);
			if (fs > SAMPLE_FULL)
				fs = SAMPLE_FULL;
			write_cfg(REG_NOISE_FLOOR, fl);
			write_cfg(REG_FULL_SCALE, fs);
			write_cfg(REG_MID_SHIFT, $urandom_range(0, 15));
			write_cfg(REG_ATTACK_SHIFT, $urandom_range(0, 15));
			write_cfg(REG_RELEASE_SHIFT, $urandom_range(0, 15));
		end
	endtask

	initial begin : result_pacing
		pace_t pace;
		int    left;
		int    pattern;
		result_ch.ready = 1'b0;
		pace = PACE_FREE;
		left = 0;
		pattern = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
			end
			if (left == 0) begin
				pace = pace_t'($urandom_range(0, 3));
				left = $urandom_range(20, 80);
				pattern = $urandom;
			end
			left--;
			case (pace)
				PACE_FREE:   result_ch.ready <= 1'b1;
				PACE_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
				PACE_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
				default: begin
					result_ch.ready <= pattern[0];
					pattern = {pattern[0], pattern[31:1]};
				end
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		follow_t want;
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (result_ch.valid && result_ch.ready) begin
				if (pending.size() == 0) begin
					report_mismatch("unexpected result", result_ch.envelope, 0);
				end else begin
					want = pending.pop_front();
					if (result_ch.pwm_duty !== want.duty)
						report_mismatch("pwm_duty", result_ch.pwm_duty, want.duty);
					if (result_ch.envelope !== want.env)
						report_mismatch("envelope", result_ch.envelope, want.env);
					if (result_ch.amplitude !== want.amp)
						report_mismatch("amplitude", result_ch.amplitude, want.amp);
					if (result_ch.midpoint !== want.mid)
						report_mismatch("midpoint", result_ch.midpoint, want.mid);
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[audio_envelope_to_duty_top] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		wave_t wave;
		int    seg_left;
		int    dc;
		int    amp;
		int    period;
		int    ph;
		int    pos;
		int    v;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NOISE_FLOOR;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		mismatches = 0;
		burst_left = 0;
		idle_cycles = 0;
		long_hold_req = 1'b0;
		floor_lvl = int'(FLOOR_RESET);
		full_lvl = int'(FULL_RESET);
		mid_sh = int'(MID_SHIFT_RESET);
		atk_sh = int'(ATK_SHIFT_RESET);
		rel_sh = int'(REL_SHIFT_RESET);
		mid_est = int'(MIDPOINT_RESET);
		env_est = 0;
		seg_left = 0;
		wave = WAVE_TONE;
		dc = 2048;
		amp = 0;
		period = 2;
		ph = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			case (DIRECTED[i].kind)
				ROW_WRITE: begin
					settle_block();
					write_cfg(DIRECTED[i].idx, DIRECTED[i].value);
				end
				ROW_CHECKED: send_sample(DIRECTED[i].value, 1'b1, DIRECTED[i].lit);
				default:     send_sample(DIRECTED[i].value, 1'b0, NO_LIT);
			endcase
		end

		for (int p = 0; p < PHASES; p++) begin
			pick_config(p);
			// The result side holds off for a long stretch while samples keep coming.
			if (p == 3)
				long_hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 5 && n == PHASE_ITEMS / 2)
					settle_block();
				if (seg_left == 0) begin
					v = $urandom_range(0, 6);
					wave = (v < 4) ? WAVE_TONE : wave_t'(v - 3);
					seg_left = $urandom_range(10, 60);
					dc = $urandom_range(1024, 3072);
					amp = $urandom_range(0, 2047);
					period = $urandom_range(2, 40);
					ph = 0;
				end
				seg_left--;
				case (wave)
					WAVE_TONE: begin
						pos = ph % period;
						if (pos < period / 2)
							v = dc - amp + (4 * amp * pos) / period;
						else
							v = dc + amp - (4 * amp * (pos - period / 2)) / period;
						ph++;
					end
					WAVE_NOISE: v = $urandom_range(0, SAMPLE_FULL);
					WAVE_QUIET: v = dc + $urandom_range(0, 32) - 16;
					default:    v = $urandom_range(0, 1) ? SAMPLE_FULL - $urandom_range(0, 3)
						: $urandom_range(0, 3);
				endcase
				if (v < 0)
					v = 0;
				if (v > SAMPLE_FULL)
					v = SAMPLE_FULL;
				send_sample(SAMPLE_BITS'(v), 1'b0, NO_LIT);
			end
		end

		settle_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[audio_envelope_to_duty_top] OK");
		else
			$display("[audio_envelope_to_duty_top] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
